// ===== design/crc32_pkg.sv =====
// Shared constants and helper functions for the programmable reflected CRC-32.
// No dependencies; imported by crc32_poly, crc32_fold and the top level.
package crc32_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

    // tuser codes
    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    localparam t_crc CRC_ALL_ONES     = 32'hFFFF_FFFF;
    localparam t_crc CRC_DEFAULT_POLY = 32'h04C1_1DB7;
    // Values taken as already reflected
    localparam t_crc CRC_REFL_IEEE       = 32'hEDB8_8320;
    localparam t_crc CRC_REFL_CASTAGNOLI = 32'h82F6_3B78;
    localparam t_crc CRC_REFL_KOOPMAN    = 32'hEB31_D82E;

    function automatic t_crc bit_reverse(input t_crc v);
        t_crc r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    function automatic t_crc reflect_poly(input t_crc p);
        t_crc r;
        if (p == CRC_REFL_IEEE || p == CRC_REFL_CASTAGNOLI || p == CRC_REFL_KOOPMAN) begin
            r = p;
        end else begin
            r = bit_reverse(p);
        end
        return r;
    endfunction

endpackage

// ===== design/crc32_reflected_programmable.sv =====
// Top level of the byte-serial reflected CRC-32 with programmable polynomial.
// Depends on crc32_pkg, crc32_poly and crc32_fold.
//
// Usage:
//   Slave stream: one word per byte. tuser is the kind (0 = fold tdata,
//   1 = restart the register to all ones; tdata ignored). tdata is the byte.
//   Master stream: one word per accepted input word, tdata = digest, the
//   inverted CRC register after that word.
//   Config: i_cfg_we with i_cfg_wdata writes the polynomial in normal bit
//   order; the running register is untouched. Write only while idle.
// Timing: the digest appears on the master side in the cycle after the word
//   is accepted. Throughput: one word per cycle unless the master side stalls;
//   the eight-step fold is one combinational pass from CRC to output register.
// Reset: register to all ones, polynomial to 0x04C11DB7, output empty.
// Stall: the output register holds its word; the slave side stays ready
//   while that register is empty or being taken in the same cycle.
module crc32_reflected_programmable
    import crc32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] digest
);

    t_crc  rpoly;
    t_crc  folded;
    logic  accept;

    t_crc  r_crc;
    t_crc  n_crc;
    logic  r_valid;
    logic  n_valid;
    t_crc  r_digest;
    t_crc  n_digest;

    crc32_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_wdata (i_cfg_wdata),
        .o_rpoly (rpoly)
    );

    crc32_fold u_fold (
        .i_crc   (r_crc),
        .i_byte  (i_s_tdata),
        .i_rpoly (rpoly),
        .o_crc   (folded)
    );

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_crc    = r_crc;
        n_digest = r_digest;
        n_valid  = r_valid && !i_m_tready;
        if (accept) begin
            n_crc    = (t_kind'(i_s_tuser) == KIND_RESTART) ? CRC_ALL_ONES : folded;
            n_digest = ~n_crc;
            n_valid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_ALL_ONES;
            r_valid <= 1'b0;
        end else begin
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digest <= n_digest;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_digest;

    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted word produced no output");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tuser |=> o_m_tdata == '0)
        else $error("restart digest not zero");

    a_digest_tracks_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata == ~r_crc)
        else $error("held digest out of step with CRC register");

    a_crc_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_crc))
        else $error("CRC register moved without an accepted word");

endmodule

// ===== design/crc32_poly.sv =====
// Polynomial register: holds the generator in reflected form, ready for the fold.
// Depends on crc32_pkg.
module crc32_poly
    import crc32_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_we,
    input  t_crc i_wdata,
    output t_crc o_rpoly
);

    t_crc r_rpoly;
    t_crc n_rpoly;

    // reflection done once at write time, not on the byte path
    always_comb begin
        n_rpoly = i_we ? reflect_poly(i_wdata) : r_rpoly;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpoly <= reflect_poly(CRC_DEFAULT_POLY);
        end else begin
            r_rpoly <= n_rpoly;
        end
    end

    assign o_rpoly = r_rpoly;

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |=> r_rpoly == reflect_poly($past(i_wdata)))
        else $error("polynomial write not captured");

    a_rpoly_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_we |=> $stable(r_rpoly))
        else $error("polynomial changed without a write");

    a_reset_default: assert property (@(posedge i_clk)
        !i_rst_n |=> r_rpoly == CRC_REFL_IEEE)
        else $error("polynomial reset value wrong");

endmodule

// ===== design/crc32_fold.sv =====
// Combinational byte fold: eight LSB-first shift/xor steps of the reflected CRC.
// Depends on crc32_pkg.
module crc32_fold
    import crc32_pkg::*;
(
    input  t_crc  i_crc,
    input  t_byte i_byte,
    input  t_crc  i_rpoly,
    output t_crc  o_crc
);

    t_crc v;

    always_comb begin
        v = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            v = v[0] ? ((v >> 1) ^ i_rpoly) : (v >> 1);
        end
        o_crc = v;
    end

endmodule
